### rtl/bcsr_pkg.sv
// ----------------------------------------------------------------------------
// bcsr_pkg
// Shared types and codes of the block-CSR sparse matrix-vector engine.
// ----------------------------------------------------------------------------
package bcsr_pkg;

    localparam logic [2:0] CMD_WR_X = 3'd0;
    localparam logic [2:0] CMD_WR_Y = 3'd1;
    localparam logic [2:0] CMD_MAT  = 3'd2;
    localparam logic [2:0] CMD_END  = 3'd3;
    localparam logic [2:0] CMD_RD_Y = 3'd4;

    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BETA  = 2'd1;
    localparam logic [1:0] CFG_TRANS = 2'd2;
    localparam logic [1:0] CFG_BW    = 2'd3;

    localparam logic FOP_MUL = 1'b0;
    localparam logic FOP_ADD = 1'b1;

    localparam logic [63:0] ALPHA_RESET = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

    typedef struct packed {
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

endpackage

### rtl/bcsr_in_if.sv
// ----------------------------------------------------------------------------
// bcsr_in_if
// Command channel: one item per command with index and value bits.
// ----------------------------------------------------------------------------
interface bcsr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [9:0]  index;
    logic [63:0] value_bits;

    modport source (output valid, output cmd, output index, output value_bits, input ready);
    modport sink   (input valid, input cmd, input index, input value_bits, output ready);
endinterface

### rtl/bcsr_out_if.sv
// ----------------------------------------------------------------------------
// bcsr_out_if
// Result channel: y element returned by a read command.
// ----------------------------------------------------------------------------
interface bcsr_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  read_index;
    logic [63:0] read_value_bits;

    modport source (output valid, output read_index, output read_value_bits, input ready);
    modport sink   (input valid, input read_index, input read_value_bits, output ready);
endinterface

### rtl/bcsr_ram.sv
// ----------------------------------------------------------------------------
// bcsr_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bcsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bcsr_fpu.sv
// ----------------------------------------------------------------------------
// bcsr_fpu
// Multi-cycle IEEE double multiply or add, round to nearest-even.
// ----------------------------------------------------------------------------
module bcsr_fpu
    import bcsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_fpu_req    i_req,
    output logic        o_done,
    output logic [63:0] o_result
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_PREP  = 3'd1;
    localparam logic [2:0] F_MUL   = 3'd2;
    localparam logic [2:0] F_ADD   = 3'd3;
    localparam logic [2:0] F_NORM  = 3'd4;
    localparam logic [2:0] F_ROUND = 3'd5;

    localparam logic [107:0] ONES = {108{1'b1}};

    logic [2:0]          r_state;
    logic                r_op;
    logic [63:0]         r_a;
    logic [63:0]         r_b;
    logic                r_sign;
    logic                r_zsign;
    logic                r_sub;
    logic signed [13:0]  r_be;
    logic [52:0]         r_ma;
    logic [55:0]         r_mb;
    logic [109:0]        r_acc;
    logic [1:0]          r_cnt;
    logic [107:0]        r_sig;
    logic [107:0]        r_y;
    logic [2:0]          r_step;
    logic [63:0]         r_res;
    logic                r_done;

    // operand decode
    logic [10:0]  a_exp, b_exp, a_e, b_e, big_e, sml_e, d;
    logic [52:0]  a_man, b_man, big_man, sml_man;
    logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
    logic         spec;
    logic [63:0]  spec_res;
    logic [107:0] sml_src, sml_al;

    always_comb begin
        a_exp  = r_a[62:52];
        b_exp  = r_b[62:52];
        a_nan  = (a_exp == 11'h7FF) && (r_a[51:0] != 52'd0);
        b_nan  = (b_exp == 11'h7FF) && (r_b[51:0] != 52'd0);
        a_inf  = (a_exp == 11'h7FF) && (r_a[51:0] == 52'd0);
        b_inf  = (b_exp == 11'h7FF) && (r_b[51:0] == 52'd0);
        a_zero = (r_a[62:0] == 63'd0);
        b_zero = (r_b[62:0] == 63'd0);
        a_man  = {(a_exp != 11'd0), r_a[51:0]};
        b_man  = {(b_exp != 11'd0), r_b[51:0]};
        a_e    = (a_exp == 11'd0) ? 11'd1 : a_exp;
        b_e    = (b_exp == 11'd0) ? 11'd1 : b_exp;
        swap   = (r_b[62:0] > r_a[62:0]);
        big_e   = swap ? b_e : a_e;
        sml_e   = swap ? a_e : b_e;
        big_man = swap ? b_man : a_man;
        sml_man = swap ? a_man : b_man;
        d       = big_e - sml_e;
        sml_src = {1'b0, sml_man, 54'd0};
        if (d >= 11'd108) begin
            sml_al = {107'd0, |sml_man};
        end else begin
            sml_al = (sml_src >> d) | {107'd0, |(sml_src & ~(ONES << d))};
        end

        spec     = 1'b1;
        spec_res = DEFAULT_NAN;
        if (a_nan) begin
            spec_res = r_a | QUIET_BIT;
        end else if (b_nan) begin
            spec_res = r_b | QUIET_BIT;
        end else if (r_op == FOP_MUL) begin
            if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                spec_res = DEFAULT_NAN;
            end else if (a_inf || b_inf) begin
                spec_res = {r_a[63] ^ r_b[63], 11'h7FF, 52'd0};
            end else begin
                spec = 1'b0;
            end
        end else begin
            if (a_inf && b_inf && (r_a[63] != r_b[63])) begin
                spec_res = DEFAULT_NAN;
            end else if (a_inf) begin
                spec_res = r_a;
            end else if (b_inf) begin
                spec_res = r_b;
            end else begin
                spec = 1'b0;
            end
        end
    end

    // partial product step
    logic [13:0]  chunk;
    logic [109:0] acc_next;

    always_comb begin
        case (r_cnt)
            2'd3:    chunk = r_mb[55:42];
            2'd2:    chunk = r_mb[41:28];
            2'd1:    chunk = r_mb[27:14];
            default: chunk = r_mb[13:0];
        endcase
        acc_next = (r_acc << 14) + 110'(r_ma * chunk);
    end

    // normalize step
    logic [6:0]         k;
    logic signed [13:0] k_s;
    logic [107:0]       n_sig;
    logic signed [13:0] n_be;

    always_comb begin
        k     = 7'd64 >> r_step;
        k_s   = 14'(k);
        n_sig = r_sig;
        n_be  = r_be;
        if ((r_step == 3'd0) && (r_be < -14'sd126)) begin
            n_sig = {107'd0, |r_sig};
            n_be  = 14'sd1;
        end else if (r_be <= (14'sd1 - k_s)) begin
            n_sig = (r_sig >> k) | {107'd0, |(r_sig & ~(ONES << k))};
            n_be  = r_be + k_s;
        end else if ((r_be > k_s) && ((r_sig & ~(ONES >> k)) == 108'd0)) begin
            n_sig = r_sig << k;
            n_be  = r_be - k_s;
        end
    end

    // round and pack
    logic [52:0]        mant;
    logic               rnd_inc;
    logic [53:0]        m;
    logic signed [13:0] be_f;
    logic               sgn;
    logic [63:0]        rnd_res;

    always_comb begin
        mant    = r_sig[107:55];
        rnd_inc = r_sig[54] & ((|r_sig[53:0]) | mant[0]);
        m       = {1'b0, mant} + 54'(rnd_inc);
        be_f    = m[53] ? (r_be + 14'sd1) : r_be;
        sgn     = (r_sig == 108'd0) ? r_zsign : r_sign;
        if (be_f >= 14'sd2047) begin
            rnd_res = {sgn, 11'h7FF, 52'd0};
        end else if (m[53]) begin
            rnd_res = {sgn, be_f[10:0], 52'd0};
        end else begin
            rnd_res = {sgn, (m[52] ? r_be[10:0] : 11'd0), m[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_state <= F_PREP;
                    end
                end
                F_PREP: begin
                    r_step <= 3'd0;
                    if (spec) begin
                        r_res   <= spec_res;
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else if (r_op == FOP_MUL) begin
                        r_sign  <= r_a[63] ^ r_b[63];
                        r_zsign <= r_a[63] ^ r_b[63];
                        r_be    <= 14'(a_e) + 14'(b_e) - 14'sd1022;
                        r_ma    <= a_man;
                        r_mb    <= {3'd0, b_man};
                        r_acc   <= 110'd0;
                        r_cnt   <= 2'd3;
                        r_state <= F_MUL;
                    end else begin
                        r_sign  <= swap ? r_b[63] : r_a[63];
                        r_zsign <= r_a[63] & r_b[63];
                        r_sub   <= r_a[63] ^ r_b[63];
                        r_be    <= 14'(big_e) + 14'sd1;
                        r_sig   <= {1'b0, big_man, 54'd0};
                        r_y     <= sml_al;
                        r_state <= F_ADD;
                    end
                end
                F_MUL: begin
                    r_acc <= acc_next;
                    r_cnt <= r_cnt - 2'd1;
                    if (r_cnt == 2'd0) begin
                        r_sig   <= {acc_next[105:0], 2'b00};
                        r_state <= F_NORM;
                    end
                end
                F_ADD: begin
                    r_sig   <= r_sub ? (r_sig - r_y) : (r_sig + r_y);
                    r_state <= F_NORM;
                end
                F_NORM: begin
                    r_sig  <= n_sig;
                    r_be   <= n_be;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd6) begin
                        r_state <= F_ROUND;
                    end
                end
                F_ROUND: begin
                    r_res   <= rnd_res;
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### rtl/block_csr_spmv_engine_core.sv
// ----------------------------------------------------------------------------
// block_csr_spmv_engine_core
// Block-CSR (1 by c) sparse matrix-vector multiply in IEEE double, with x and
// y held in on-chip RAM.
//
//   channel   dir  handshake            payload
//   i_in      in   valid/ready          cmd, index, value_bits
//   o_out     out  valid/ready          read_index, read_value_bits
//   i_cfg_*   in   write enable only    addr, wdata (64)
//
// One item at a time. A matrix value is a multiply and then an add through
// the shared floating-point unit; an element out of range skips the unit,
// and the first value of a row first scales x[row] by alpha. A row end in
// normal mode scales the sum by alpha and y by beta, adds, and writes y;
// in transposed mode it only closes the row and moves on to the next row.
// Reset is synchronous and clears control state; x and y RAM are not cleared.
// A held result stalls only the next read command.
// ----------------------------------------------------------------------------
module block_csr_spmv_engine_core
    import bcsr_pkg::*;
#(
    parameter int VECTOR_DEPTH    = 1024,
    parameter int MAX_BLOCK_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bcsr_in_if.sink       i_in,
    bcsr_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [63:0]   i_cfg_wdata
);

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int LW = $clog2(MAX_BLOCK_WIDTH + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_RDY    = 5'd2;
    localparam logic [4:0] S_OPEN   = 5'd3;
    localparam logic [4:0] S_OPEN_W = 5'd4;
    localparam logic [4:0] S_MV     = 5'd5;
    localparam logic [4:0] S_MV_X   = 5'd6;
    localparam logic [4:0] S_MV_M   = 5'd7;
    localparam logic [4:0] S_MV_A   = 5'd8;
    localparam logic [4:0] S_MV_TM  = 5'd9;
    localparam logic [4:0] S_MV_TR  = 5'd10;
    localparam logic [4:0] S_MV_TA  = 5'd11;
    localparam logic [4:0] S_LANE   = 5'd12;
    localparam logic [4:0] S_ER_A   = 5'd13;
    localparam logic [4:0] S_ER_B   = 5'd14;
    localparam logic [4:0] S_ER_BW  = 5'd15;
    localparam logic [4:0] S_ER_S   = 5'd16;
    localparam logic [4:0] S_ER_FIN = 5'd17;

    logic [4:0]    r_state;
    logic [4:0]    n_state;
    logic [2:0]    r_cmd;
    logic [9:0]    r_idx;
    logic [63:0]   r_val;
    logic [63:0]   r_alpha;
    logic [63:0]   r_beta;
    logic          r_tmode;
    logic [4:0]    r_bw;
    logic [63:0]   r_acc;
    logic [63:0]   r_scaled;
    logic [63:0]   r_prod;
    logic [9:0]    r_row;
    logic [LW-1:0] r_lane;
    logic          r_row_open;
    logic [AW-1:0] r_elem;
    logic          r_out_valid;
    logic [9:0]    r_out_idx;
    logic [63:0]   r_out_val;

    logic          x_we;
    logic [AW-1:0] x_addr;
    logic [63:0]   x_rdata;
    logic          y_we;
    logic [AW-1:0] y_addr;
    logic [63:0]   y_wdata;
    logic [63:0]   y_rdata;
    logic          fpu_start;
    t_fpu_req      fpu_req;
    logic          fpu_done;
    logic [63:0]   fpu_res;

    logic          accept;
    logic          out_free;
    logic          idx_in;
    logic          row_in;
    logic          elem_in;
    logic [AW-1:0] idx_addr;
    logic [AW-1:0] row_addr;
    logic [31:0]   elem32;
    logic [31:0]   c32;
    logic [31:0]   lane_inc;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign idx_in   = 32'(r_idx) < VECTOR_DEPTH;
    assign row_in   = 32'(r_row) < VECTOR_DEPTH;
    assign idx_addr = AW'(r_idx);
    assign row_addr = AW'(r_row);
    assign elem32   = 32'(r_idx) + 32'(r_lane);
    assign elem_in  = elem32 < VECTOR_DEPTH;
    assign lane_inc = 32'(r_lane) + 32'd1;

    always_comb begin
        if (r_bw == 5'd0) begin
            c32 = 32'd1;
        end else if (32'(r_bw) > MAX_BLOCK_WIDTH) begin
            c32 = MAX_BLOCK_WIDTH;
        end else begin
            c32 = 32'(r_bw);
        end
    end

    bcsr_ram #(.WIDTH(64), .DEPTH(VECTOR_DEPTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_addr  (x_addr),
        .i_wdata (r_val),
        .o_rdata (x_rdata)
    );

    bcsr_ram #(.WIDTH(64), .DEPTH(VECTOR_DEPTH)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_addr  (y_addr),
        .i_wdata (y_wdata),
        .o_rdata (y_rdata)
    );

    bcsr_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (fpu_start),
        .i_req    (fpu_req),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    always_comb begin
        n_state   = r_state;
        x_we      = 1'b0;
        x_addr    = idx_addr;
        y_we      = 1'b0;
        y_addr    = idx_addr;
        y_wdata   = r_val;
        fpu_start = 1'b0;
        fpu_req   = '{op: FOP_MUL, a: r_val, b: r_val};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd)
                    CMD_WR_X: begin
                        x_we    = idx_in;
                        n_state = S_IDLE;
                    end
                    CMD_WR_Y: begin
                        y_we    = idx_in;
                        n_state = S_IDLE;
                    end
                    CMD_RD_Y: begin
                        n_state = S_RDY;
                    end
                    CMD_MAT: begin
                        if (!r_row_open) begin
                            x_addr  = row_addr;
                            n_state = S_OPEN;
                        end else begin
                            n_state = S_MV;
                        end
                    end
                    CMD_END: begin
                        if (!r_tmode && row_in) begin
                            fpu_start = 1'b1;
                            fpu_req   = '{op: FOP_MUL, a: r_acc, b: r_alpha};
                            n_state   = S_ER_A;
                        end else begin
                            n_state = S_ER_FIN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_OPEN: begin
                fpu_start = 1'b1;
                fpu_req   = '{op: FOP_MUL, a: (row_in ? x_rdata : 64'd0), b: r_alpha};
                n_state   = S_OPEN_W;
            end
            S_OPEN_W: begin
                if (fpu_done) begin
                    n_state = S_MV;
                end
            end
            S_MV: begin
                if (elem_in && !r_tmode) begin
                    x_addr  = elem32[AW-1:0];
                    n_state = S_MV_X;
                end else if (elem_in && r_tmode && row_in) begin
                    fpu_start = 1'b1;
                    fpu_req   = '{op: FOP_MUL, a: r_val, b: r_scaled};
                    n_state   = S_MV_TM;
                end else begin
                    n_state = S_LANE;
                end
            end
            S_MV_X: begin
                fpu_start = 1'b1;
                fpu_req   = '{op: FOP_MUL, a: r_val, b: x_rdata};
                n_state   = S_MV_M;
            end
            S_MV_M: begin
                if (fpu_done) begin
                    fpu_start = 1'b1;
                    fpu_req   = '{op: FOP_ADD, a: r_acc, b: fpu_res};
                    n_state   = S_MV_A;
                end
            end
            S_MV_A: begin
                if (fpu_done) begin
                    n_state = S_LANE;
                end
            end
            S_MV_TM: begin
                if (fpu_done) begin
                    y_addr  = r_elem;
                    n_state = S_MV_TR;
                end
            end
            S_MV_TR: begin
                fpu_start = 1'b1;
                fpu_req   = '{op: FOP_ADD, a: y_rdata, b: fpu_res};
                n_state   = S_MV_TA;
            end
            S_MV_TA: begin
                if (fpu_done) begin
                    y_we    = 1'b1;
                    y_addr  = r_elem;
                    y_wdata = fpu_res;
                    n_state = S_LANE;
                end
            end
            S_LANE: begin
                n_state = S_IDLE;
            end
            S_ER_A: begin
                if (fpu_done) begin
                    y_addr  = row_addr;
                    n_state = S_ER_B;
                end
            end
            S_ER_B: begin
                fpu_start = 1'b1;
                fpu_req   = '{op: FOP_MUL, a: y_rdata, b: r_beta};
                n_state   = S_ER_BW;
            end
            S_ER_BW: begin
                if (fpu_done) begin
                    fpu_start = 1'b1;
                    fpu_req   = '{op: FOP_ADD, a: fpu_res, b: r_prod};
                    n_state   = S_ER_S;
                end
            end
            S_ER_S: begin
                if (fpu_done) begin
                    y_we    = 1'b1;
                    y_addr  = row_addr;
                    y_wdata = fpu_res;
                    n_state = S_ER_FIN;
                end
            end
            S_ER_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= ALPHA_RESET;
            r_beta      <= 64'd0;
            r_tmode     <= 1'b0;
            r_bw        <= 5'd1;
            r_acc       <= 64'd0;
            r_scaled    <= 64'd0;
            r_row       <= 10'd0;
            r_lane      <= '0;
            r_row_open  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ALPHA: r_alpha <= i_cfg_wdata;
                    CFG_BETA:  r_beta  <= i_cfg_wdata;
                    CFG_TRANS: r_tmode <= i_cfg_wdata[0];
                    CFG_BW:    r_bw    <= i_cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_in.cmd;
                        r_idx <= i_in.index;
                        r_val <= i_in.value_bits;
                    end
                end
                S_DISP: begin
                    if ((r_cmd == CMD_MAT) && (32'(r_lane) >= c32)) begin
                        r_lane <= '0;
                    end
                end
                S_RDY: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= idx_in ? r_idx : 10'd0;
                        r_out_val   <= idx_in ? y_rdata : 64'd0;
                    end
                end
                S_OPEN_W: begin
                    if (fpu_done) begin
                        r_scaled   <= fpu_res;
                        r_row_open <= 1'b1;
                    end
                end
                S_MV: begin
                    r_elem <= elem32[AW-1:0];
                end
                S_MV_A: begin
                    if (fpu_done) begin
                        r_acc <= fpu_res;
                    end
                end
                S_LANE: begin
                    r_lane <= (lane_inc >= c32) ? '0 : lane_inc[LW-1:0];
                end
                S_ER_A: begin
                    if (fpu_done) begin
                        r_prod <= fpu_res;
                    end
                end
                S_ER_FIN: begin
                    r_acc      <= 64'd0;
                    r_lane     <= '0;
                    r_row_open <= 1'b0;
                    r_row      <= r_row + 10'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.read_index      = r_out_idx;
    assign o_out.read_value_bits = r_out_val;

endmodule
